// ===== rtl/core/bcgc_pkg.sv =====
// Shared constants and types for the box cull graph compactor.
package bcgc_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int COORD_BITS = 16;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int EXT_W      = COORD_BITS + 2;
    localparam int ADDR_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int IDX_W      = 12;
    localparam int ENTRY_W    = IDX_W + 1;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int CULL_W     = 13;
    localparam int DROP_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NODE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z   = 3'd5;

    localparam logic [CULL_W-1:0] CULL_SAT = '1;
    localparam logic [DROP_W-1:0] DROP_SAT = '1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic [HALF_BITS-1:0]         half_x;
        logic [HALF_BITS-1:0]         half_y;
        logic [HALF_BITS-1:0]         half_z;
    } t_box_cfg;

    typedef struct packed {
        logic               keep;
        logic [IDX_W-1:0]   idx;
    } t_entry;

endpackage

// ===== rtl/core/bcgc_if.sv =====
// Request channel interfaces for node/edge items and compacted results.
interface bcgc_in_if import bcgc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [MODE_W-1:0]            mode;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [IDX_W-1:0]             edge_first;
    logic [IDX_W-1:0]             edge_second;

    modport source (output valid, mode, coord_x, coord_y, coord_z, edge_first, edge_second,
                    input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z, edge_first, edge_second,
                    output ready);
endinterface

interface bcgc_out_if import bcgc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kept;
    logic [IDX_W-1:0]  out_first;
    logic [IDX_W-1:0]  out_second;
    logic              overflow;
    logic [CULL_W-1:0] removed_nodes;
    logic [DROP_W-1:0] removed_edges;

    modport source (output valid, kept, out_first, out_second, overflow, removed_nodes,
                    removed_edges, input ready);
    modport sink   (input valid, kept, out_first, out_second, overflow, removed_nodes,
                    removed_edges, output ready);
endinterface

// ===== rtl/core/bcgc_box_test.sv =====
// Inclusive axis-aligned box containment test on three signed coordinates.
module bcgc_box_test import bcgc_pkg::*; (
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic signed [COORD_BITS-1:0] i_coord_z,
    input  t_box_cfg                     i_cfg,
    output logic                         o_inside
);

    logic signed [EXT_W-1:0] pos [3];
    logic signed [EXT_W-1:0] ctr [3];
    logic signed [EXT_W-1:0] hlf [3];
    logic signed [EXT_W-1:0] lo  [3];
    logic signed [EXT_W-1:0] hi  [3];
    logic [2:0]              in_axis;

    assign pos[0] = EXT_W'(i_coord_x);
    assign pos[1] = EXT_W'(i_coord_y);
    assign pos[2] = EXT_W'(i_coord_z);
    assign ctr[0] = EXT_W'(i_cfg.center_x);
    assign ctr[1] = EXT_W'(i_cfg.center_y);
    assign ctr[2] = EXT_W'(i_cfg.center_z);
    assign hlf[0] = $signed(EXT_W'(i_cfg.half_x));
    assign hlf[1] = $signed(EXT_W'(i_cfg.half_y));
    assign hlf[2] = $signed(EXT_W'(i_cfg.half_z));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo[i]      = ctr[i] - hlf[i];
            hi[i]      = ctr[i] + hlf[i];
            in_axis[i] = (pos[i] >= lo[i]) && (pos[i] <= hi[i]);
        end
    end

    assign o_inside = &in_axis;

endmodule

// ===== rtl/core/bcgc_remap_ram.sv =====
// Remap table: one write port, two registered read ports.
module bcgc_remap_ram import bcgc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output t_entry            o_rdata_a,
    output t_entry            o_rdata_b
);

    t_entry mem [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ===== rtl/core/box_cull_graph_compactor_top.sv =====
// Box cull graph compactor: culls nodes inside a box and remaps surviving edges.
//
// Usage:
//   i_in carries one request per item: mode start, node or edge. A start
//   request clears the node and edge counters. Node requests are tested
//   against the box and numbered densely if outside it; edge requests look
//   up both endpoints in the remap table and survive only if both were kept.
//   o_out returns exactly one result request per input request, in order.
//   The box is set through the write port (i_cfg_we, i_cfg_idx, i_cfg_data)
//   while no request is in flight.
// Timing:
//   An accepted item passes the lookup stage (registered remap table read)
//   and then the output register. Throughput is one item per cycle while
//   o_out is not stalled, as each item needs at most one table access (node
//   items write it at acceptance, edge items read both ports at acceptance).
// Reset and stalls:
//   i_rst_n (synchronous) clears counters and valid flags and loads the
//   default box; the table stays undefined until nodes are written. While o_out
//   is stalled, the pipeline holds one result and one item in flight, then
//   drops i_in.ready until the receiver takes the result.
module box_cull_graph_compactor_top import bcgc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    bcgc_in_if.sink               i_in,
    bcgc_out_if.source            o_out
);

    t_box_cfg          r_cfg;
    logic [CNT_W-1:0]  r_nodes_seen, n_nodes_seen;
    logic [CNT_W-1:0]  r_nodes_kept, n_nodes_kept;
    logic [CULL_W-1:0] r_culled, n_culled;
    logic [DROP_W-1:0] r_dropped, n_dropped;

    logic              acc;
    logic              in_box;
    logic              full;
    logic              wr_en;
    t_entry            wr_data;
    logic              rd_en;
    t_entry            rd_a, rd_b;
    logic              a_ok, b_ok;
    logic              acc_kept, acc_ovf;
    logic [IDX_W-1:0]  acc_first;

    logic              r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic              r_s1_kept;
    logic [IDX_W-1:0]  r_s1_first;
    logic              r_s1_ovf;
    logic [CULL_W-1:0] r_s1_culled;
    logic              r_s1_a_ok, r_s1_b_ok;
    logic              s1_adv;
    logic              s1_kept;
    logic [IDX_W-1:0]  s1_first, s1_second;

    logic              r_out_valid;
    logic              r_out_kept;
    logic [IDX_W-1:0]  r_out_first, r_out_second;
    logic              r_out_ovf;
    logic [CULL_W-1:0] r_out_culled;
    logic [DROP_W-1:0] r_out_dropped;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= COORD_BITS'(0);
            r_cfg.center_y <= COORD_BITS'(-819);
            r_cfg.center_z <= COORD_BITS'(573);
            r_cfg.half_x   <= HALF_BITS'(1229);
            r_cfg.half_y   <= HALF_BITS'(860);
            r_cfg.half_z   <= HALF_BITS'(1229);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                CFG_CENTER_Z: r_cfg.center_z <= i_cfg_data;
                CFG_HALF_X:   r_cfg.half_x   <= i_cfg_data[HALF_BITS-1:0];
                CFG_HALF_Y:   r_cfg.half_y   <= i_cfg_data[HALF_BITS-1:0];
                CFG_HALF_Z:   r_cfg.half_z   <= i_cfg_data[HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    bcgc_box_test u_box (
        .i_coord_x (i_in.coord_x),
        .i_coord_y (i_in.coord_y),
        .i_coord_z (i_in.coord_z),
        .i_cfg     (r_cfg),
        .o_inside  (in_box)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign acc        = i_in.valid && i_in.ready;
    assign full       = (r_nodes_seen == CNT_W'(MAX_NODES));
    assign a_ok       = CMP_W'(i_in.edge_first) < CMP_W'(r_nodes_seen);
    assign b_ok       = CMP_W'(i_in.edge_second) < CMP_W'(r_nodes_seen);

    // acceptance stage: node counters and table write
    always_comb begin
        n_nodes_seen = r_nodes_seen;
        n_nodes_kept = r_nodes_kept;
        n_culled     = r_culled;
        wr_en        = 1'b0;
        wr_data      = '0;
        rd_en        = 1'b0;
        acc_kept     = 1'b0;
        acc_ovf      = 1'b0;
        acc_first    = '0;
        case (i_in.mode)
            MODE_START: begin
                n_nodes_seen = '0;
                n_nodes_kept = '0;
                n_culled     = '0;
            end
            MODE_NODE: begin
                if (full) begin
                    acc_ovf = 1'b1;
                end else begin
                    wr_en        = acc;
                    n_nodes_seen = r_nodes_seen + CNT_W'(1);
                    if (in_box) begin
                        if (r_culled != CULL_SAT) begin
                            n_culled = r_culled + CULL_W'(1);
                        end
                    end else begin
                        wr_data.keep = 1'b1;
                        wr_data.idx  = IDX_W'(r_nodes_kept);
                        acc_kept     = 1'b1;
                        acc_first    = IDX_W'(r_nodes_kept);
                        n_nodes_kept = r_nodes_kept + CNT_W'(1);
                    end
                end
            end
            MODE_EDGE: begin
                rd_en = acc;
            end
            default: ;
        endcase
    end

    bcgc_remap_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (ADDR_W'(r_nodes_seen)),
        .i_wdata   (wr_data),
        .i_re      (rd_en),
        .i_raddr_a (ADDR_W'(i_in.edge_first)),
        .i_raddr_b (ADDR_W'(i_in.edge_second)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_seen <= '0;
            r_nodes_kept <= '0;
            r_culled     <= '0;
        end else if (acc) begin
            r_nodes_seen <= n_nodes_seen;
            r_nodes_kept <= n_nodes_kept;
            r_culled     <= n_culled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mode   <= i_in.mode;
            r_s1_kept   <= acc_kept;
            r_s1_first  <= acc_first;
            r_s1_ovf    <= acc_ovf;
            r_s1_culled <= n_culled;
            r_s1_a_ok   <= a_ok;
            r_s1_b_ok   <= b_ok;
        end
    end

    // lookup stage: edge resolution and drop counter
    always_comb begin
        s1_kept   = r_s1_kept;
        s1_first  = r_s1_first;
        s1_second = '0;
        n_dropped = r_dropped;
        case (r_s1_mode)
            MODE_START: n_dropped = '0;
            MODE_EDGE: begin
                s1_kept = r_s1_a_ok && rd_a.keep && r_s1_b_ok && rd_b.keep;
                if (s1_kept) begin
                    s1_first  = rd_a.idx;
                    s1_second = rd_b.idx;
                end else if (r_dropped != DROP_SAT) begin
                    n_dropped = r_dropped + DROP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropped <= '0;
        end else if (s1_adv) begin
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_kept    <= s1_kept;
            r_out_first   <= s1_first;
            r_out_second  <= s1_second;
            r_out_ovf     <= r_s1_ovf;
            r_out_culled  <= r_s1_culled;
            r_out_dropped <= n_dropped;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kept          = r_out_kept;
    assign o_out.out_first     = r_out_first;
    assign o_out.out_second    = r_out_second;
    assign o_out.overflow      = r_out_ovf;
    assign o_out.removed_nodes = r_out_culled;
    assign o_out.removed_edges = r_out_dropped;

`ifndef SYNTHESIS
    a_kept_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes_kept <= r_nodes_seen)
        else $error("kept node count exceeds seen count");

    a_seen_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nodes_seen <= CNT_W'(MAX_NODES))
        else $error("seen node count beyond capacity");

    a_ovf_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> !o_out.kept && o_out.out_first == '0)
        else $error("overflow result marked kept");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.kept |-> o_out.out_first == '0 && o_out.out_second == '0)
        else $error("dropped result carries indices");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_valid && o_out.valid && !o_out.ready)
        else $error("input stalled without a full pipeline");
`endif

endmodule
